### rtl/fmbs_pkg.sv
// Shared types and constants for the FLAC metadata block stripper.
// Depends on nothing; every other file in rtl/ refers to it by scoped names.
package fmbs_pkg;

   // Status codes reported with the end-of-file byte.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BADMARK   = 2'd1;
   localparam logic [1:0] STATUS_TRUNCHDR  = 2'd2;
   localparam logic [1:0] STATUS_NOAUDIO   = 2'd3;

   localparam logic [7:0] LAST_FLAG_MASK = 8'h80;
   localparam logic [1:0] HEADER_LAST_IDX = 2'd3;

   // Depth of the queue between the parser and the output stage.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // One classified byte, as handed from the parser to the output stage.
   typedef struct packed {
      logic [7:0] data;
      logic       pass;
      logic       eof;
      logic [1:0] status;
   } entry_type;

   // The four-byte stream marker "fLaC".
   function automatic logic [7:0] marker_byte(input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0: b = 8'h66;
         2'd1: b = 8'h4C;
         2'd2: b = 8'h61;
         2'd3: b = 8'h43;
         default: b = 8'h66;
      endcase
      return b;
   endfunction

endpackage

### rtl/fmbs_front.sv
// Parser front end: tracks marker, header and body position of the stream.
// Classifies each request byte and pushes the result into the queue. Uses fmbs_pkg.
module fmbs_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         in_byte,
   input  logic               end_of_file,
   output fmbs_pkg::entry_type entry
);

   typedef enum logic [2:0] {
      PH_MARKER = 3'd0,
      PH_HEADER = 3'd1,
      PH_BODY   = 3'd2,
      PH_AUDIO  = 3'd3,
      PH_ERROR  = 3'd4
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [1:0]  idx_ff, idx_in;
   logic [23:0] skip_ff, skip_in;
   logic        last_ff, last_in;
   logic [1:0]  err_ff, err_in;

   logic [23:0] skip_shift;
   logic [23:0] skip_dec;

   assign skip_shift = (idx_ff == 2'd0) ? 24'd0 : {skip_ff[15:0], in_byte};
   assign skip_dec   = (skip_ff != 24'd0) ? (skip_ff - 24'd1) : skip_ff;

   always_comb begin
      phase_in     = phase_ff;
      idx_in       = idx_ff;
      skip_in      = skip_ff;
      last_in      = last_ff;
      err_in       = err_ff;
      entry.data   = in_byte;
      entry.pass   = 1'b0;
      entry.eof    = end_of_file;
      entry.status = fmbs_pkg::STATUS_OK;

      case (phase_ff)
         PH_MARKER: begin
            if (in_byte != fmbs_pkg::marker_byte(idx_ff)) begin
               phase_in     = PH_ERROR;
               err_in       = fmbs_pkg::STATUS_BADMARK;
               entry.status = fmbs_pkg::STATUS_BADMARK;
            end else if (idx_ff == fmbs_pkg::HEADER_LAST_IDX) begin
               phase_in     = PH_HEADER;
               idx_in       = 2'd0;
               entry.status = fmbs_pkg::STATUS_TRUNCHDR;
            end else begin
               idx_in       = idx_ff + 2'd1;
               entry.status = fmbs_pkg::STATUS_BADMARK;
            end
         end
         PH_HEADER: begin
            if (idx_ff == 2'd0) begin
               last_in = (in_byte & fmbs_pkg::LAST_FLAG_MASK) != 8'd0;
            end
            skip_in = skip_shift;
            if (idx_ff == fmbs_pkg::HEADER_LAST_IDX) begin
               idx_in = 2'd0;
               if (skip_shift == 24'd0) begin
                  phase_in = last_ff ? PH_AUDIO : PH_HEADER;
               end else begin
                  phase_in = PH_BODY;
               end
               entry.status = fmbs_pkg::STATUS_NOAUDIO;
            end else begin
               idx_in       = idx_ff + 2'd1;
               entry.status = fmbs_pkg::STATUS_TRUNCHDR;
            end
         end
         PH_BODY: begin
            skip_in = skip_dec;
            if (skip_dec == 24'd0) begin
               phase_in = last_ff ? PH_AUDIO : PH_HEADER;
               if (!last_ff) begin
                  idx_in = 2'd0;
               end
            end
            entry.status = fmbs_pkg::STATUS_NOAUDIO;
         end
         PH_AUDIO: begin
            entry.pass = 1'b1;
         end
         default: begin
            entry.status = err_ff;
         end
      endcase

      if (!end_of_file) begin
         entry.status = fmbs_pkg::STATUS_OK;
      end else begin
         // The end of a file returns the parser to its start for the next file.
         phase_in = PH_MARKER;
         idx_in   = 2'd0;
         skip_in  = 24'd0;
         last_in  = 1'b0;
         err_in   = fmbs_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_MARKER;
         idx_ff   <= 2'd0;
         skip_ff  <= 24'd0;
         last_ff  <= 1'b0;
         err_ff   <= fmbs_pkg::STATUS_OK;
      end else if (accept) begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         skip_ff  <= skip_in;
         last_ff  <= last_in;
         err_ff   <= err_in;
      end
   end

endmodule

### rtl/fmbs_queue.sv
// Short first-in first-out queue of classified bytes between parser and output.
// Uses fmbs_pkg for the entry type and depth.
module fmbs_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  fmbs_pkg::entry_type push_entry,
   input  logic                pop,
   output fmbs_pkg::entry_type head_entry,
   output logic                full,
   output logic                empty
);

   fmbs_pkg::entry_type slot_ff [fmbs_pkg::QUEUE_DEPTH];

   logic [fmbs_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [fmbs_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [fmbs_pkg::QUEUE_AW:0]   count_ff, count_in;

   assign full       = (count_ff == (fmbs_pkg::QUEUE_AW + 1)'(fmbs_pkg::QUEUE_DEPTH));
   assign empty      = (count_ff == '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? (wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? (rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/fmbs_back.sv
// Output stage: takes classified bytes from the queue and forms the response.
// Holds the response register behind the rsp_ handshake. Uses fmbs_pkg.
module fmbs_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                empty,
   input  fmbs_pkg::entry_type head_entry,
   output logic                pop,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_out_valid,
   output logic                rsp_file_done,
   output logic [1:0]          rsp_status
);

   logic       valid_ff;
   logic [7:0] byte_ff, byte_in;
   logic       pass_ff;
   logic       done_ff;
   logic [1:0] status_ff;

   // Load a new response whenever the register is empty or being taken.
   assign pop     = !empty && (!valid_ff || rsp_ready);
   assign byte_in = head_entry.pass ? head_entry.data : 8'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         byte_ff   <= byte_in;
         pass_ff   <= head_entry.pass;
         done_ff   <= head_entry.eof;
         status_ff <= head_entry.status;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_out_valid = pass_ff;
   assign rsp_file_done = done_ff;
   assign rsp_status    = status_ff;

endmodule

### rtl/flac_metadata_block_stripper_core.sv
// FLAC metadata block stripper: one response per request byte, one byte per cycle
// while responses are taken. A request passes through the queue, then the response
// register, before its response is valid.
// The parser state update is a single step that sets the rate.
// Synchronous active-high reset returns the parser to the marker check and empties
// the queue and the response register.
module flac_metadata_block_stripper_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_file,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_valid,
   output logic       rsp_file_done,
   output logic [1:0] rsp_status
);

   // The parser takes a request whenever the queue has room. It classifies the
   // byte from its current phase (marker, header, body, audio or error) and
   // writes the classification straight into the queue.
   fmbs_pkg::entry_type front_entry;
   fmbs_pkg::entry_type head_entry;
   logic                accept;
   logic                q_full;
   logic                q_empty;
   logic                pop;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   fmbs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .in_byte     (req_in_byte),
      .end_of_file (req_end_of_file),
      .entry       (front_entry)
   );

   // The queue lets the parser keep taking bytes while a response stalls.
   fmbs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_entry (front_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .full       (q_full),
      .empty      (q_empty)
   );

   // The output stage zeroes bytes that are not audio and holds each response
   // in a register until it is taken.
   fmbs_back u_back (
      .clock         (clock),
      .reset         (reset),
      .empty         (q_empty),
      .head_entry    (head_entry),
      .pop           (pop),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_valid (rsp_out_valid),
      .rsp_file_done (rsp_file_done),
      .rsp_status    (rsp_status)
   );

endmodule
